// ===== hdl/stack_watermark_scanner_top_macros.svh =====
// Assertion macros used by the stack watermark scanner top level.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef STACK_WATERMARK_SCANNER_TOP_MACROS_SVH
`define STACK_WATERMARK_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SWSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SWSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/swsc_pkg.sv =====
// Shared types and constants for the stack watermark scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package swsc_pkg;

  localparam int unsigned NumRegStacks = 3;
  localparam int unsigned AddrW        = 32;
  localparam int unsigned CntW         = 17;
  localparam int unsigned SelW         = 2;
  localparam int unsigned IdxW         = 3;
  localparam int unsigned PctScale     = 100;
  localparam int unsigned PctLimit     = 80;
  localparam int unsigned ProdW        = CntW + 7;

  // Configuration register indexes.
  localparam logic [IdxW-1:0] REG_MAIN_BASE  = 3'd0;
  localparam logic [IdxW-1:0] REG_MAIN_WORDS = 3'd1;
  localparam logic [IdxW-1:0] REG_IRQ_BASE   = 3'd2;
  localparam logic [IdxW-1:0] REG_IRQ_WORDS  = 3'd3;
  localparam logic [IdxW-1:0] REG_SUP_BASE   = 3'd4;
  localparam logic [IdxW-1:0] REG_SUP_WORDS  = 3'd5;

  localparam logic [CntW-1:0] WordsReset = 17'd1024;

  typedef enum logic [1:0] {
    EV_MATCH    = 2'd0,
    EV_MISMATCH = 2'd1,
    EV_CLEAN    = 2'd2
  } scan_event_e;

  // Configuration of one stack as seen by the compare logic.
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [CntW-1:0]  count;
  } stk_cfg_t;

  // Scan state of one stack.
  typedef struct packed {
    logic [CntW-1:0] pos;
    logic [CntW-1:0] used;
  } stk_state_t;

  // State write-back from the compare logic.
  typedef struct packed {
    logic            we;
    logic [SelW-1:0] sel;
    stk_state_t      state;
  } stk_upd_t;

  // One result item.
  typedef struct packed {
    logic [SelW-1:0]  stack_echo;
    logic [AddrW-1:0] next_address;
    logic [CntW-1:0]  used_words;
    scan_event_e      scan_event;
    logic             usage_alarm;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/stack_watermark_scanner_top.sv =====
// Top level of the stack watermark scanner: stream ports, input and result
// registers. Depends on swsc_pkg, swsc_cfg_regs, swsc_state and swsc_eval.
`default_nettype none
`include "stack_watermark_scanner_top_macros.svh"

// The scanner checks painted stacks for their high-water mark. Each request
// names a stack and carries the memory word read at that stack's current scan
// address; the word is expected to equal the inverted byte address. A match
// advances the scan, a full clean pass reports used words of zero, and a
// mismatch reports used = count - position and raises the alarm when usage is at
// least eighty-one percent. Every request with a stack number of 0 to 2 yields
// exactly one result; other stack numbers are taken and dropped silently.
// Throughput is one request per clock while the master side takes results; a
// stalled master side holds the input register. A request waits in the input
// register, is evaluated and written to the result register, and the per-stack
// state is updated at the edge of that load, so a request for the same stack in
// the following cycle already sees the new position. The result is offered on
// the master side from the result register until it is taken.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i and
// should only change while no request is in flight; scan state survives it.
module stack_watermark_scanner_top #(
  parameter int unsigned NUM_STACKS = 3,
  parameter int unsigned MAX_WORDS  = 65536
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Slave side.
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] read_word
  input  wire  [1:0]  s_axis_tuser,   // [1:0] stack_select
  // Master side.
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [31:0] next_address, [48:32] used_words, rest zero
  output logic [4:0]  m_axis_tuser,   // [1:0] stack_echo, [3:2] scan_event, [4] usage_alarm
  // Configuration write port.
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [31:0] cfg_wdata_i
);
  import swsc_pkg::*;

  // Only stacks that have both registers and state are served.
  localparam int unsigned NumEnt = (NUM_STACKS < NumRegStacks) ? NUM_STACKS : NumRegStacks;

  // Input register.
  logic             in_vld_q, in_vld_d;
  logic [SelW-1:0]  in_sel_q;
  logic [AddrW-1:0] in_word_q;

  // Result register.
  logic    out_vld_q, out_vld_d;
  result_t out_q;

  logic       advance;
  logic       in_take;
  logic       sel_ok;
  stk_cfg_t   cur_cfg;
  stk_state_t cur_state;
  stk_upd_t   upd;
  stk_upd_t   upd_gated;
  result_t    res;

  // The input item moves into the result register when that is free or drained.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign sel_ok        = (32'(s_axis_tuser) < 32'(NumEnt));

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = sel_ok;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sel_q  <= s_axis_tuser;
      in_word_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  swsc_cfg_regs #(
    .MAX_WORDS (MAX_WORDS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sel_i       (in_sel_q),
    .cfg_o       (cur_cfg)
  );

  swsc_state #(
    .NUM_ENT (NumEnt)
  ) u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sel_i   (in_sel_q),
    .state_o (cur_state),
    .upd_i   (upd_gated)
  );

  swsc_eval u_eval (
    .vld_i   (in_vld_q),
    .sel_i   (in_sel_q),
    .word_i  (in_word_q),
    .cfg_i   (cur_cfg),
    .state_i (cur_state),
    .res_o   (res),
    .upd_o   (upd)
  );

  // State is committed on the same edge as the result register load.
  always_comb begin
    upd_gated    = upd;
    upd_gated.we = upd.we && advance;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.used_words, out_q.next_address};
  assign m_axis_tuser  = {out_q.usage_alarm, out_q.scan_event, out_q.stack_echo};

  `SWSC_ASSERT_IMP(a_alarm_only_on_mismatch,
                   m_axis_tvalid && out_q.usage_alarm,
                   out_q.scan_event == EV_MISMATCH,
                   "usage alarm on a result that is not a mismatch")
  `SWSC_ASSERT_IMP(a_clean_has_no_usage,
                   m_axis_tvalid && (out_q.scan_event == EV_CLEAN),
                   out_q.used_words == '0,
                   "clean scan reports nonzero usage")
  `SWSC_ASSERT_IMP(a_mismatch_has_usage,
                   m_axis_tvalid && (out_q.scan_event == EV_MISMATCH),
                   out_q.used_words != '0,
                   "mismatch reports zero usage")
  `SWSC_ASSERT_NXT(a_held_item_kept,
                   in_vld_q && !advance,
                   in_vld_q && $stable(in_sel_q) && $stable(in_word_q),
                   "stalled input item lost or changed")
  `SWSC_ASSERT_IMP(a_state_write_with_load,
                   upd_gated.we,
                   advance && in_vld_q,
                   "state written without a result load")

endmodule

`default_nettype wire

// ===== hdl/swsc_cfg_regs.sv =====
// Configuration registers: base address and word count of each stack.
// Depends on swsc_pkg; presents the selected stack's effective count.
`default_nettype none

module swsc_cfg_regs #(
  parameter int unsigned MAX_WORDS = 65536
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [swsc_pkg::IdxW-1:0]      cfg_idx_i,
  input  wire [swsc_pkg::AddrW-1:0]     cfg_wdata_i,
  input  wire [swsc_pkg::SelW-1:0]      sel_i,
  output swsc_pkg::stk_cfg_t            cfg_o
);
  import swsc_pkg::*;

  // Largest count a 17-bit register can express, capped by MAX_WORDS.
  localparam int unsigned CntMax = (1 << CntW) - 1;
  localparam int unsigned CapCnt = (MAX_WORDS < CntMax) ? MAX_WORDS : CntMax;

  logic [AddrW-1:0] base_q  [NumRegStacks];
  logic [CntW-1:0]  words_q [NumRegStacks];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegStacks; i++) begin
        base_q[i]  <= '0;
        words_q[i] <= WordsReset;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAIN_BASE:  base_q[0]  <= cfg_wdata_i;
        REG_MAIN_WORDS: words_q[0] <= cfg_wdata_i[CntW-1:0];
        REG_IRQ_BASE:   base_q[1]  <= cfg_wdata_i;
        REG_IRQ_WORDS:  words_q[1] <= cfg_wdata_i[CntW-1:0];
        REG_SUP_BASE:   base_q[2]  <= cfg_wdata_i;
        REG_SUP_WORDS:  words_q[2] <= cfg_wdata_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] words_sel;

  always_comb begin
    cfg_o     = '0;
    words_sel = '0;
    for (int i = 0; i < NumRegStacks; i++) begin
      if (sel_i == SelW'(i)) begin
        cfg_o.base = base_q[i];
        words_sel  = words_q[i];
      end
    end
    // A count of zero acts as one word; anything above the cap is clamped.
    if (words_sel == '0) begin
      cfg_o.count = CntW'(1);
    end else if (32'(words_sel) > 32'(CapCnt)) begin
      cfg_o.count = CntW'(CapCnt);
    end else begin
      cfg_o.count = words_sel;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/swsc_state.sv =====
// Per-stack scan position and used-word count registers.
// Depends on swsc_pkg; one read port by stack number, one write-back port.
`default_nettype none

module swsc_state #(
  parameter int unsigned NUM_ENT = 3
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire [swsc_pkg::SelW-1:0] sel_i,
  output swsc_pkg::stk_state_t     state_o,
  input  swsc_pkg::stk_upd_t       upd_i
);
  import swsc_pkg::*;

  stk_state_t state_q [NUM_ENT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        state_q[i] <= '0;
      end
    end else if (upd_i.we) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        if (upd_i.sel == SelW'(i)) begin
          state_q[i] <= upd_i.state;
        end
      end
    end
  end

  always_comb begin
    state_o = '0;
    for (int i = 0; i < NUM_ENT; i++) begin
      if (sel_i == SelW'(i)) begin
        state_o = state_q[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/swsc_eval.sv =====
// Compare logic: checks one painted word and computes the new scan state.
// Depends on swsc_pkg; purely combinational.
`default_nettype none

module swsc_eval (
  input  wire                       vld_i,
  input  wire [swsc_pkg::SelW-1:0]  sel_i,
  input  wire [swsc_pkg::AddrW-1:0] word_i,
  input  swsc_pkg::stk_cfg_t        cfg_i,
  input  swsc_pkg::stk_state_t      state_i,
  output swsc_pkg::result_t         res_o,
  output swsc_pkg::stk_upd_t        upd_o
);
  import swsc_pkg::*;

  logic [CntW-1:0]  pos0;
  logic [CntW-1:0]  pos_inc;
  logic [AddrW-1:0] expect_word;
  logic [ProdW-1:0] used_scaled;
  logic [ProdW-1:0] limit_scaled;
  stk_state_t       nxt;
  scan_event_e      ev;
  logic             alarm;

  always_comb begin
    // A position left beyond a lowered count restarts at word zero.
    pos0        = (state_i.pos >= cfg_i.count) ? '0 : state_i.pos;
    pos_inc     = pos0 + CntW'(1);
    expect_word = ~(cfg_i.base + {{(AddrW-CntW-2){1'b0}}, pos0, 2'b00});
    nxt         = state_i;
    ev          = EV_MATCH;
    alarm       = 1'b0;
    used_scaled  = '0;
    limit_scaled = '0;
    if (word_i == expect_word) begin
      if (pos_inc >= cfg_i.count) begin
        nxt.pos  = '0;
        nxt.used = '0;
        ev       = EV_CLEAN;
      end else begin
        nxt.pos = pos_inc;
      end
    end else begin
      nxt.used     = cfg_i.count - pos0;
      nxt.pos      = '0;
      ev           = EV_MISMATCH;
      // At least eighty-one percent, i.e. used*100 >= 81*count.
      used_scaled  = {7'd0, nxt.used} * ProdW'(PctScale);
      limit_scaled = {7'd0, cfg_i.count} * ProdW'(PctLimit + 1);
      alarm        = (used_scaled >= limit_scaled);
    end

    res_o.stack_echo   = sel_i;
    res_o.next_address = cfg_i.base + {{(AddrW-CntW-2){1'b0}}, nxt.pos, 2'b00};
    res_o.used_words   = nxt.used;
    res_o.scan_event   = ev;
    res_o.usage_alarm  = alarm;

    upd_o.we    = vld_i;
    upd_o.sel   = sel_i;
    upd_o.state = nxt;
  end

endmodule

`default_nettype wire

// ===== tb/tb_stack_watermark_scanner_top.sv =====
// Self-checking testbench for stack_watermark_scanner_top: directed table, then random requests.
// Expected results: local scan predictor or typed table row. Needs swsc_pkg and the scanner RTL.

module tb_stack_watermark_scanner_top;
  import swsc_pkg::*;

  localparam int unsigned StackCount    = 3;
  localparam int unsigned WordsCeiling  = 65536;
  localparam int unsigned PercentScale  = 100;
  localparam int unsigned AlarmAbovePct = 80;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned SegmentCount  = 9;
  localparam int unsigned SegmentItems  = 195;
  localparam int unsigned SettleCycles  = 6;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // One line of the directed table. For a request row, painted asks for the word
  // at the stack's current scan address, with word used as an XOR mask on it;
  // otherwise word is sent as it stands. For a register row, word is the data.
  typedef struct {
    row_kind_e       kind;
    logic [IdxW-1:0] reg_idx;
    logic [1:0]      sel;
    logic            painted;
    logic [31:0]     word;
    int unsigned     reps;
    logic            typed;
    result_t         golden;
  } plan_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  stack_watermark_scanner_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Predictor state: the register file and the per-stack scan state.
  logic [31:0] stack_base  [StackCount];
  logic [16:0] stack_words [StackCount];
  logic [16:0] scan_pos    [StackCount];
  logic [16:0] used_cnt    [StackCount];

  result_t     pending_results[$];
  plan_row_t   directed_plan[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // The typed expectation, if any, that travels with the request on the bus.
  logic        req_typed;
  result_t     req_golden;

  result_t     predicted;
  result_t     oldest;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // A words register of zero means one word, anything above the ceiling is clamped.
  function automatic logic [16:0] effective_words(input logic [16:0] words);
    if (words == '0) return 17'd1;
    if (words > WordsCeiling) return 17'(WordsCeiling);
    return words;
  endfunction

  function automatic logic [31:0] word_address(input logic [31:0] base, input logic [16:0] pos);
    return base + (32'(pos) << 2);
  endfunction

  // The unused-stack fill pattern: inverted address of the word the scan looks at next.
  // A position left beyond a lowered count restarts at word zero.
  function automatic logic [31:0] painted_word(input logic [1:0] sel);
    logic [16:0] pos;
    pos = scan_pos[sel];
    if (pos >= effective_words(stack_words[sel])) pos = '0;
    return ~word_address(stack_base[sel], pos);
  endfunction

  // Advances the scan of one stack by one compared word and returns the result.
  function automatic result_t scan_predict(input logic [1:0] sel, input logic [31:0] word);
    result_t     r;
    logic [16:0] cnt;
    logic [16:0] pos;
    logic [16:0] used;
    r = '0;
    cnt = effective_words(stack_words[sel]);
    pos = scan_pos[sel];
    if (pos >= cnt) pos = '0;
    if (word == ~word_address(stack_base[sel], pos)) begin
      pos = pos + 17'd1;
      r.scan_event = EV_MATCH;
      if (pos >= cnt) begin
        used_cnt[sel] = '0;
        pos = '0;
        r.scan_event = EV_CLEAN;
      end
    end else begin
      used = cnt - pos;
      used_cnt[sel] = used;
      pos = '0;
      r.scan_event = EV_MISMATCH;
      // Above eighty percent in whole percent steps means at least 81 percent.
      r.usage_alarm = (64'(used) * PercentScale >= 64'(AlarmAbovePct + 1) * 64'(cnt));
    end
    scan_pos[sel] = pos;
    r.stack_echo = sel;
    r.next_address = word_address(stack_base[sel], pos);
    r.used_words = used_cnt[sel];
    return r;
  endfunction

  function automatic result_t make_result(input logic [1:0] echo, input logic [31:0] addr,
                                          input logic [16:0] used, input scan_event_e ev,
                                          input logic alarm);
    result_t r;
    r.stack_echo   = echo;
    r.next_address = addr;
    r.used_words   = used;
    r.scan_event   = ev;
    r.usage_alarm  = alarm;
    return r;
  endfunction

  task automatic plan_cfg(input logic [IdxW-1:0] idx, input logic [31:0] data);
    plan_row_t row;
    row = '{kind: ROW_CFG, reg_idx: idx, sel: 2'd0, painted: 1'b0, word: data, reps: 1,
            typed: 1'b0, golden: '0};
    directed_plan.push_back(row);
  endtask

  task automatic plan_req(input logic [1:0] sel, input logic painted, input logic [31:0] word,
                          input int unsigned reps, input logic typed, input result_t golden);
    plan_row_t row;
    row = '{kind: ROW_REQ, reg_idx: '0, sel: sel, painted: painted, word: word, reps: reps,
            typed: typed, golden: golden};
    directed_plan.push_back(row);
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Drives one request from the falling edge, idling first at the sender's rate,
  // and returns right after the rising edge that accepts it. The painted word is
  // computed only now, so the predictor already holds every earlier request.
  task automatic send_request(input logic [1:0] sel, input logic painted,
                              input logic [31:0] word, input logic typed,
                              input result_t golden);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = sel;
    s_axis_tdata  = (painted && sel < StackCount) ? painted_word(sel) ^ word : word;
    req_typed     = typed;
    req_golden    = golden;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Waits until every expected result has come back, then lets the pipeline settle,
  // since requests for the unused stack number leave no result to wait for.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes one register and mirrors it into the predictor. Even indexes hold a
  // base, odd ones a word count, two per stack.
  task automatic write_register(input logic [IdxW-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    if (idx[0]) stack_words[idx[2:1]] = data[16:0];
    else stack_base[idx[2:1]] = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Receiver: ready is redrawn at every falling edge at the current stall rate.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Scoreboard. Accepted requests for a known stack go through the predictor; a
  // row of the directed table with a typed expectation queues that one instead,
  // while the predictor state still moves on. Results are checked in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready && s_axis_tuser < StackCount) begin
        predicted = scan_predict(s_axis_tuser, s_axis_tdata);
        pending_results.push_back(req_typed ? req_golden : predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request pending, actual tdata %0h tuser %0h",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          oldest = pending_results.pop_front();
          check_field("stack_echo", 32'(oldest.stack_echo), 32'(m_axis_tuser[1:0]));
          check_field("scan_event", 32'(oldest.scan_event), 32'(m_axis_tuser[3:2]));
          check_field("usage_alarm", 32'(oldest.usage_alarm), 32'(m_axis_tuser[4]));
          check_field("next_address", oldest.next_address, m_axis_tdata[31:0]);
          check_field("used_words", 32'(oldest.used_words), 32'(m_axis_tdata[48:32]));
          check_field("tdata padding", 32'd0, 32'(m_axis_tdata[55:49]));
        end
      end
    end
  end

  // Watchdog: a run that hangs or loses results ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [1:0]  sel;
    logic        painted;
    logic [31:0] word;
    int unsigned roll;
    plan_row_t   row;

    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    req_typed      = 1'b0;
    req_golden     = '0;
    mismatch_count = 0;
    send_idle_pct  = 6;
    recv_idle_pct  = 56;
    for (int s = 0; s < StackCount; s++) begin
      stack_base[s]  = '0;
      stack_words[s] = WordsReset;
      scan_pos[s]    = '0;
      used_cnt[s]    = '0;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table. Right after reset every base is zero and every stack holds
    // 1024 words, so the first results can be read off directly.
    plan_req(2'd0, 1'b1, 32'h0, 1, 1'b1, make_result(2'd0, 32'h4, 17'd0, EV_MATCH, 1'b0));
    plan_req(2'd0, 1'b0, 32'h0, 1, 1'b1,
             make_result(2'd0, 32'h0, 17'd1023, EV_MISMATCH, 1'b1));
    // The unused stack number is swallowed without a result.
    plan_req(2'd3, 1'b0, 32'hFFFF_FFFF, 1, 1'b0, '0);
    plan_req(2'd1, 1'b0, 32'h0, 1, 1'b1,
             make_result(2'd1, 32'h0, 17'd1024, EV_MISMATCH, 1'b1));
    // A word count of zero behaves as a single-word stack at the top of memory.
    plan_cfg(REG_SUP_WORDS, 32'h0);
    plan_cfg(REG_SUP_BASE, 32'hFFFF_FFFC);
    plan_req(2'd2, 1'b1, 32'h0, 1, 1'b1,
             make_result(2'd2, 32'hFFFF_FFFC, 17'd0, EV_CLEAN, 1'b0));
    plan_req(2'd2, 1'b0, 32'h0, 1, 1'b1,
             make_result(2'd2, 32'hFFFF_FFFC, 17'd1, EV_MISMATCH, 1'b1));
    // Oversized count is clamped; the scan address wraps past the top.
    plan_cfg(REG_MAIN_WORDS, 32'h1_FFFF);
    plan_cfg(REG_MAIN_BASE, 32'hFFFF_FFF8);
    plan_req(2'd0, 1'b1, 32'h0, 3, 1'b0, '0);
    plan_req(2'd0, 1'b0, 32'h0, 1, 1'b0, '0);
    // Lowering the count below the scan position makes the scan restart.
    plan_cfg(REG_IRQ_WORDS, 32'd10);
    plan_cfg(REG_IRQ_BASE, 32'h2000_0000);
    plan_req(2'd1, 1'b1, 32'h0, 6, 1'b0, '0);
    plan_cfg(REG_IRQ_WORDS, 32'd4);
    plan_req(2'd1, 1'b1, 32'h0, 3, 1'b0, '0);
    // A single flipped bit near the end is a low-usage mismatch with no alarm.
    plan_req(2'd1, 1'b1, 32'h1, 1, 1'b0, '0);

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_register(row.reg_idx, row.word);
      end else begin
        repeat (row.reps) send_request(row.sel, row.painted, row.word, row.typed, row.golden);
      end
    end

    // Random segments: three idle profiles, three register settings each. Settings
    // cycle through the extremes of base and word count; small counts dominate
    // so that full clean passes occur often.
    for (int seg = 0; seg < SegmentCount; seg++) begin
      wait_drained();
      case (seg / 3)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < StackCount; s++) begin
        case ((seg * 2 + s) % 4)
          0: word = 32'h0;
          1: word = 32'hFFFF_FFFC;
          2: word = $urandom & 32'hFFFF_FFFC;
          default: word = $urandom;
        endcase
        write_register(IdxW'(2 * s), word);
        case ((seg + s) % 7)
          0: word = 32'd0;
          1: word = 32'h1_FFFF;
          2: word = 32'd65536;
          3: word = 32'd1;
          default: word = $urandom_range(24, 2);
        endcase
        write_register(IdxW'(2 * s + 1), word);
      end

      // Mostly painted words so that scans run deep, some near misses, some noise.
      for (int n = 0; n < SegmentItems; n++) begin
        sel  = ($urandom_range(99) < 5) ? 2'd3 : 2'($urandom_range(StackCount - 1));
        roll = $urandom_range(99);
        painted = (roll < 92);
        if (roll < 84) word = 32'h0;
        else if (roll < 92) word = 32'h1 << $urandom_range(31);
        else word = $urandom;
        send_request(sel, painted, word, 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
